FILE: hw/rtl/srt_pkg.sv
// Shared types, constants and helpers for the segment reassembly tracker.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package srt_pkg;
	localparam int ENTRIES      = 8;
	localparam int MAX_SEGMENTS = 32;
	localparam int KEY_BITS     = 64;
	localparam int TIME_BITS    = 32;
	localparam int SEG_W        = 6;
	localparam int CNT_W        = $clog2(ENTRIES + 1);
	localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int MAPI_W       = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int QDEPTH       = 2;
	localparam int QA_W         = $clog2(QDEPTH);
	localparam int CFG_AW       = 3;
	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

	typedef enum logic [2:0] {
		KIND_SEGMENT = 3'd0,
		KIND_TICK    = 3'd1,
		KIND_SWEEP   = 3'd2,
		KIND_CLEANUP = 3'd3,
		KIND_PROBE   = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_NOSEG    = 4'd0,
		ST_STORED   = 4'd1,
		ST_DUP      = 4'd2,
		ST_BADIDX   = 4'd3,
		ST_COMPLETE = 4'd4,
		ST_FULL     = 4'd5,
		ST_EVICTED  = 4'd6,
		ST_SWEPT    = 4'd7,
		ST_CLEANED  = 4'd8,
		ST_ABSENT   = 4'd9,
		ST_PROBED   = 4'd10,
		ST_TICKED   = 4'd11
	} status_t;

	typedef enum logic [2:0] {
		OP_NOSEG, OP_SEGMENT, OP_TICK, OP_SWEEP, OP_CLEANUP, OP_PROBE
	} op_t;

	typedef struct packed {
		logic [2:0]          kind;
		logic [63:0]         key;
		logic                segmented;
		logic [SEG_W-1:0]    seg_idx;
		logic [SEG_W-1:0]    seg_total;
	} in_item_t;

	typedef struct packed {
		logic [3:0]          status;
		logic [63:0]         result_key;
		logic [SEG_W-1:0]    rcv_count;
		logic [SEG_W-1:0]    expected_total;
		logic [3:0]          live_cnt;
		logic                found;
		logic                last;
	} out_item_t;

	typedef struct packed {
		op_t                 op;
		logic [KEY_BITS-1:0] key;
		logic [SEG_W-1:0]    sidx;
		logic [SEG_W-1:0]    stot;
	} cmd_t;

	function automatic logic [CNT_W-1:0] count_valid(input logic [ENTRIES-1:0] v);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			n = n + CNT_W'(v[i]);
		end
		return n;
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/srt_front.sv
// Front end: accepts input items, decodes the kind and drops unused kinds.
// Depends on srt_pkg; feeds the command queue.
`default_nettype none
module srt_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire srt_pkg::in_item_t in_item,
	output logic                   cmd_valid,
	input  wire logic              cmd_ready,
	output srt_pkg::cmd_t          cmd
);
	import srt_pkg::*;

	logic  valid_s1;
	cmd_t  cmd_s1;
	cmd_t  dec;
	logic  keep;

	always_comb begin
		dec.key  = in_item.key[KEY_BITS-1:0];
		dec.sidx = in_item.seg_idx;
		dec.stot = in_item.seg_total;
		dec.op   = OP_TICK;
		keep     = 1'b1;
		case (in_item.kind)
			KIND_SEGMENT: dec.op = in_item.segmented ? OP_SEGMENT : OP_NOSEG;
			KIND_TICK:    dec.op = OP_TICK;
			KIND_SWEEP:   dec.op = OP_SWEEP;
			KIND_CLEANUP: dec.op = OP_CLEANUP;
			KIND_PROBE:   dec.op = OP_PROBE;
			default:      keep   = 1'b0;
		endcase
	end

	assign in_ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= dec;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/srt_queue.sv
// Short command queue between the front end and the table engine.
// Depends on srt_pkg for the command type and depth.
`default_nettype none
module srt_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire srt_pkg::cmd_t  push_cmd,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output srt_pkg::cmd_t       pop_cmd
);
	import srt_pkg::*;

	cmd_t             slot_q [QDEPTH];
	logic [QA_W-1:0]  wr_q;
	logic [QA_W-1:0]  rd_q;
	logic [QA_W:0]    fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = fill_q != (QA_W+1)'(QDEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_cmd    = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			fill_q <= fill_q + (QA_W+1)'(do_push) - (QA_W+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_cmd;
	end
endmodule
`default_nettype wire

FILE: hw/rtl/srt_back.sv
// Table engine: holds the entry table and time counter, runs commands and sweeps.
// Depends on srt_pkg; drives the registered result channel.
`default_nettype none
module srt_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [31:0]       timeout_ticks,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire srt_pkg::cmd_t     cmd,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output srt_pkg::out_item_t     out_item
);
	import srt_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_DONE} state_t;

	state_t                    state_q;
	logic [IDX_W-1:0]          widx_q;
	logic [ENTRIES-1:0]        valid_q;
	logic [KEY_BITS-1:0]       key_q   [ENTRIES];
	logic [SEG_W-1:0]          tot_q   [ENTRIES];
	logic [SEG_W-1:0]          cnt_q   [ENTRIES];
	logic [MAX_SEGMENTS-1:0]   map_q   [ENTRIES];
	logic [TIME_BITS-1:0]      act_q   [ENTRIES];
	logic [TIME_BITS-1:0]      time_q;
	logic                      out_valid_q;
	out_item_t                 out_q;

	logic                      slot_free;
	logic [ENTRIES-1:0]        hit;
	logic                      hit_any, free_any;
	logic [IDX_W-1:0]          hit_idx, free_idx, sel;
	logic [SEG_W-1:0]          tot_new, cur_tot, cur_cnt, new_cnt;
	logic [MAX_SEGMENTS-1:0]   cur_map, bit_mask;
	logic [MAPI_W-1:0]         bitpos;
	logic                      bad, dup, complete;
	logic [TIME_BITS-1:0]      idle;
	logic                      expired;
	logic [ENTRIES-1:0]        valid_nx;
	logic                      run, write_seg;
	logic                      res_load;
	out_item_t                 res;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign cmd_ready = (state_q == S_IDLE) && slot_free;
	assign run       = cmd_valid && cmd_ready;

	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			hit[i] = valid_q[i] && (key_q[i] == cmd.key);
			if (hit[i]) begin
				hit_any = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
		sel      = hit_any ? hit_idx : free_idx;
		tot_new  = (cmd.stot > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : cmd.stot;
		cur_tot  = hit_any ? tot_q[sel] : tot_new;
		cur_cnt  = hit_any ? cnt_q[sel] : '0;
		cur_map  = hit_any ? map_q[sel] : '0;
		bad      = (cmd.sidx == '0) || (cmd.sidx > cur_tot);
		bitpos   = MAPI_W'(cmd.sidx - 1'b1);
		bit_mask = MAX_SEGMENTS'(1) << bitpos;
		dup      = cur_map[bitpos];
		new_cnt  = bad ? cur_cnt : (dup ? cur_cnt : cur_cnt + 1'b1);
		complete = !bad && (new_cnt == cur_tot);
		idle     = time_q - act_q[widx_q];
		expired  = valid_q[widx_q] && (TIME_BITS'(idle) > TIME_BITS'(timeout_ticks));

		valid_nx  = valid_q;
		write_seg = 1'b0;
		res       = '0;
		res.last  = 1'b1;
		if (state_q == S_IDLE) begin
			res.result_key = 64'(cmd.key);
			case (cmd.op)
				OP_NOSEG: res.status = ST_NOSEG;
				OP_TICK: begin
					res.status     = ST_TICKED;
					res.result_key = '0;
				end
				OP_SWEEP: res.status = ST_SWEPT;
				OP_SEGMENT: begin
					if (!hit_any && !free_any) begin
						res.status = ST_FULL;
					end else begin
						write_seg          = 1'b1;
						valid_nx[sel]      = !complete;
						res.found          = hit_any;
						res.rcv_count      = new_cnt;
						res.expected_total = cur_tot;
						if (bad)           res.status = ST_BADIDX;
						else if (complete) res.status = ST_COMPLETE;
						else if (dup)      res.status = ST_DUP;
						else               res.status = ST_STORED;
					end
				end
				OP_CLEANUP, OP_PROBE: begin
					if (!hit_any) begin
						res.status = ST_ABSENT;
					end else begin
						res.status         = (cmd.op == OP_CLEANUP) ? ST_CLEANED : ST_PROBED;
						res.found          = 1'b1;
						res.rcv_count      = cnt_q[hit_idx];
						res.expected_total = tot_q[hit_idx];
						if (cmd.op == OP_CLEANUP) valid_nx[hit_idx] = 1'b0;
					end
				end
				default: res.status = ST_NOSEG;
			endcase
		end else if (state_q == S_SWEEP) begin
			res.status         = ST_EVICTED;
			res.result_key     = 64'(key_q[widx_q]);
			res.rcv_count      = cnt_q[widx_q];
			res.expected_total = tot_q[widx_q];
			res.found          = 1'b1;
			res.last           = 1'b0;
			if (expired) valid_nx[widx_q] = 1'b0;
		end else begin
			res.status = ST_SWEPT;
		end
		res.live_cnt = 4'(count_valid(valid_nx));

		case (state_q)
			S_IDLE:  res_load = run && (cmd.op != OP_SWEEP);
			S_SWEEP: res_load = slot_free && expired;
			S_DONE:  res_load = slot_free;
			default: res_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			widx_q      <= '0;
			valid_q     <= '0;
			time_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_load || (out_valid_q && !out_ready);
			if (res_load) out_q <= res;
			case (state_q)
				S_IDLE: begin
					if (run) begin
						if (cmd.op == OP_SWEEP) begin
							state_q <= S_SWEEP;
							widx_q  <= '0;
						end else begin
							valid_q <= valid_nx;
							if (cmd.op == OP_TICK) time_q <= time_q + 1'b1;
						end
					end
				end
				S_SWEEP: begin
					if (slot_free) begin
						valid_q <= valid_nx;
						if (widx_q == IDX_W'(ENTRIES - 1)) state_q <= S_DONE;
						else                                widx_q  <= widx_q + 1'b1;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (run && write_seg) begin
			act_q[sel] <= time_q;
			if (!hit_any) begin
				key_q[sel] <= cmd.key;
				tot_q[sel] <= tot_new;
			end
			cnt_q[sel] <= new_cnt;
			map_q[sel] <= bad ? cur_map : (cur_map | bit_mask);
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/segment_reassembly_tracker.sv
// Top level of the segment reassembly tracker: front end, queue, table engine.
// Depends on srt_pkg, srt_front, srt_queue and srt_back; holds the timeout register.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    in_item (in_item_t)
//   out       output     out_valid/out_ready  out_item (out_item_t)
//   cfg       input      APB psel/penable     timeout_ticks at byte address 0
//
// A non-sweep item passes through the front register and the queue, and the engine
// then loads its result into the output register.
// A sweep holds the engine while it takes the command, visits each table entry in
// turn and loads the final result. Reset clears the valid bits and the time.
// A full output register stalls the engine, and the queue then backs up the front.
`default_nettype none
module segment_reassembly_tracker (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire srt_pkg::in_item_t        in_item,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output srt_pkg::out_item_t            out_item,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [srt_pkg::CFG_AW-1:0] paddr,
	input  wire logic [31:0]              pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import srt_pkg::*;

	logic        fq_valid, fq_ready, qb_valid, qb_ready;
	cmd_t        fq_cmd, qb_cmd;
	logic [31:0] timeout_q;
	logic        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[CFG_AW-1:2] == '0;
	assign prdata  = reg_sel ? timeout_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			timeout_q <= pwdata;
		end
	end

	srt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.cmd_valid (fq_valid),
		.cmd_ready (fq_ready),
		.cmd       (fq_cmd)
	);

	srt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_cmd   (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_cmd    (qb_cmd)
	);

	srt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.timeout_ticks (timeout_q),
		.cmd_valid     (qb_valid),
		.cmd_ready     (qb_ready),
		.cmd           (qb_cmd),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_item      (out_item)
	);
endmodule
`default_nettype wire

FILE: hw/rtl/srt_checker.sv
// Port-level checks for the segment reassembly tracker, bound to the top level.
// Depends on srt_pkg for the result type and status codes.
`default_nettype none
module srt_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire srt_pkg::out_item_t out_item
);
	import srt_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	a_not_last_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.last |-> out_item.status == ST_EVICTED)
		else $error("only evictions may be non-final");

	a_evict_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_EVICTED |-> out_item.found && !out_item.last)
		else $error("eviction result malformed");

	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.live_cnt <= 4'(ENTRIES))
		else $error("pending count out of range");
endmodule

bind segment_reassembly_tracker srt_checker u_srt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
`default_nettype wire
